[rtl/frew_pkg.sv]
`default_nettype none

package frew_pkg;

    // Default geometry of the flash array.
    localparam int MEM_BYTES_DEF = 65536;
    localparam int ROW_BYTES_DEF = 256;

    // Fixed field widths.
    localparam int SPAN_W    = 17;
    localparam int ADDR_IN_W = 16;
    localparam int BYTE_W    = 8;
    localparam int TOTAL_W   = 32;
    localparam int ROWS_W    = 9;

    localparam logic [SPAN_W-1:0]  SPAN_RESET  = 17'h10000;
    localparam logic [BYTE_W-1:0]  ERASED_BYTE = 8'hFF;
    localparam logic [BYTE_W-1:0]  ROW_CNT_MAX = 8'hFF;
    localparam logic [ROWS_W-1:0]  ROWS_CAP    = 9'h1FF;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX   = 32'hFFFF_FFFF;

    // Operation codes of an input beat.
    typedef enum logic [1:0] {
        FUNC_READ    = 2'd0,
        FUNC_PROGRAM = 2'd1,
        FUNC_PRELOAD = 2'd2,
        FUNC_NONE    = 2'd3
    } t_func;

endpackage

`default_nettype wire

[rtl/flash_row_erase_wear_model.sv]
`default_nettype none

// Channel   Handshake                  Payload
// input     i_in_valid / o_in_ready    i_func, i_access_address, i_write_data
// result    o_out_valid / i_out_ready  o_read_data .. o_inversion_total
// config    i_cfg_valid / o_cfg_ready  i_cfg_data (span in bytes)
//
// Reads, preloads and programs that need no erase pass from S_EVAL, which
// evaluates the registered store byte, to S_DONE, which hands the result to
// the output register, before the next beat is accepted.
// An erasing program adds S_DIV for the reciprocal multiply that finds the
// row, S_CNT_RD and S_CNT_WR for the row counter memory, S_SWEEP for each
// erased byte of the row (at most ROW_BYTES), S_PROG for the final byte write.
// After reset a clearing pass fills the store with 0xFF and zeroes the row
// counters, one byte per cycle, with o_in_ready low throughout.
// A finished result waits in the output register while the next beat is
// accepted; only a second finished result stalls behind it.

module flash_row_erase_wear_model #(
    parameter int MEM_BYTES = frew_pkg::MEM_BYTES_DEF,
    parameter int ROW_BYTES = frew_pkg::ROW_BYTES_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,

    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [1:0]                      i_func,
    input  wire logic [frew_pkg::ADDR_IN_W-1:0]  i_access_address,
    input  wire logic [frew_pkg::BYTE_W-1:0]     i_write_data,

    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic [frew_pkg::BYTE_W-1:0]          o_read_data,
    output logic                                 o_did_erase,
    output logic [frew_pkg::TOTAL_W-1:0]         o_erase_total,
    output logic [frew_pkg::TOTAL_W-1:0]         o_program_total,
    output logic [frew_pkg::ROWS_W-1:0]          o_rows_touched,
    output logic [frew_pkg::ROWS_W-1:0]          o_rows_amplified,
    output logic [frew_pkg::BYTE_W-1:0]          o_max_row_erases,
    output logic [frew_pkg::TOTAL_W-1:0]         o_inversion_total,

    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [frew_pkg::SPAN_W-1:0]     i_cfg_data
);
    import frew_pkg::*;

    localparam int ADDR_W    = $clog2(MEM_BYTES);
    localparam int NUM_ROWS  = (MEM_BYTES + ROW_BYTES - 1) / ROW_BYTES;
    localparam int RIDX_W    = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
    localparam int RB_W      = $clog2(ROW_BYTES) + 1;
    localparam int RECIP_SH  = ADDR_IN_W + $clog2(ROW_BYTES);
    localparam int RECIP_W   = ADDR_IN_W + 1;
    localparam int PROD_W    = ADDR_IN_W + RECIP_W;

    localparam logic [RB_W-1:0]    OFF_LAST  = RB_W'(ROW_BYTES - 1);
    localparam logic [ADDR_W-1:0]  PTR_LAST  = ADDR_W'(MEM_BYTES - 1);
    localparam logic [RECIP_W-1:0] RECIP_M   =
        RECIP_W'((2**RECIP_SH + ROW_BYTES - 1) / ROW_BYTES);

    typedef enum logic [8:0] {
        S_CLEAR  = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_EVAL   = 9'b000000100,
        S_DIV    = 9'b000001000,
        S_CNT_RD = 9'b000010000,
        S_CNT_WR = 9'b000100000,
        S_SWEEP  = 9'b001000000,
        S_PROG   = 9'b010000000,
        S_DONE   = 9'b100000000
    } t_state;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DOWN = 2'd2
    } t_dir;

    t_state r_state, n_state;

    // Configuration and latched input beat.
    logic [SPAN_W-1:0]    r_span;
    t_func                r_func;
    logic [ADDR_IN_W-1:0] r_addr;
    logic [BYTE_W-1:0]    r_data;

    // Shared pointer for the clearing pass and the row erase sweep.
    logic [ADDR_W-1:0]    r_ptr;
    logic [RB_W-1:0]      r_off;

    // Row index of the address, from a reciprocal multiply by the row size.
    logic [ADDR_IN_W-1:0] r_quot;

    // Statistics.
    logic [TOTAL_W-1:0]   r_erase_cnt;
    logic [TOTAL_W-1:0]   r_prog_cnt;
    logic [TOTAL_W-1:0]   r_inv_cnt;
    logic [RIDX_W-1:0]    r_last_row;
    t_dir                 r_dir;
    logic                 r_seen;
    logic [ROWS_W-1:0]    r_touched;
    logic [ROWS_W-1:0]    r_amplified;
    logic [BYTE_W-1:0]    r_peak;

    // Per-item result bits.
    logic [BYTE_W-1:0]    r_res_rd;
    logic                 r_res_erase;

    // Output register.
    logic                 r_out_valid;
    logic [BYTE_W-1:0]    r_out_read_data;
    logic                 r_out_did_erase;
    logic [TOTAL_W-1:0]   r_out_erase_total;
    logic [TOTAL_W-1:0]   r_out_program_total;
    logic [ROWS_W-1:0]    r_out_rows_touched;
    logic [ROWS_W-1:0]    r_out_rows_amplified;
    logic [BYTE_W-1:0]    r_out_max_row_erases;
    logic [TOTAL_W-1:0]   r_out_inversion_total;

    // Memories and their ports.
    logic [BYTE_W-1:0]    r_store [MEM_BYTES];
    logic [BYTE_W-1:0]    r_store_q;
    logic                 store_we;
    logic [ADDR_W-1:0]    store_waddr;
    logic [BYTE_W-1:0]    store_wdata;

    logic [BYTE_W-1:0]    r_row_cnt [NUM_ROWS];
    logic [BYTE_W-1:0]    r_row_cnt_q;
    logic                 cnt_we;
    logic [RIDX_W-1:0]    cnt_waddr;
    logic [BYTE_W-1:0]    cnt_wdata;

    logic                 in_accept;
    logic                 out_free;
    logic                 in_span;
    logic                 prog_hit;
    logic                 needs_erase;
    logic                 sweep_last;
    logic [PROD_W-1:0]    div_prod;
    logic [ADDR_IN_W-1:0] div_quot;
    logic [RIDX_W-1:0]    row_idx;
    logic [BYTE_W-1:0]    cnt_new;
    t_dir                 new_dir;

    assign in_accept = i_in_valid && o_in_ready;
    assign out_free  = !r_out_valid || i_out_ready;

    // Address checks against the effective span.
    assign in_span = (32'(r_addr) < 32'(r_span)) && (32'(r_addr) < 32'(MEM_BYTES));
    assign sweep_last = (r_off == OFF_LAST) || (r_ptr == PTR_LAST)
                      || (32'(r_ptr) + 32'd1 >= 32'(r_span));

    // Program decision from the stored byte.
    assign prog_hit    = (r_func == FUNC_PROGRAM) && in_span && (r_store_q != r_data);
    assign needs_erase = (r_store_q & r_data) != r_data;

    // Quotient by the row size: the rounded-up reciprocal is exact for any
    // 16-bit address.
    assign div_prod = {{RECIP_W{1'b0}}, r_addr} * {{ADDR_IN_W{1'b0}}, RECIP_M};
    assign div_quot = ADDR_IN_W'(div_prod >> RECIP_SH);
    assign row_idx  = RIDX_W'(r_quot);

    // Row counter update and erase direction.
    assign cnt_new = (r_row_cnt_q == ROW_CNT_MAX) ? ROW_CNT_MAX : r_row_cnt_q + 8'd1;
    assign new_dir = (row_idx > r_last_row) ? DIR_UP : DIR_DOWN;

    // Sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR:  if (r_ptr == PTR_LAST) n_state = S_IDLE;
            S_IDLE:   if (i_in_valid) n_state = S_EVAL;
            S_EVAL:   n_state = (prog_hit && needs_erase) ? S_DIV : S_DONE;
            S_DIV:    n_state = S_CNT_RD;
            S_CNT_RD: n_state = S_CNT_WR;
            S_CNT_WR: n_state = S_SWEEP;
            S_SWEEP:  if (sweep_last) n_state = S_PROG;
            S_PROG:   n_state = S_DONE;
            S_DONE:   if (out_free) n_state = S_IDLE;
            default:  n_state = S_CLEAR;
        endcase
    end

    // Byte store write port.
    always_comb begin
        store_we    = 1'b0;
        store_waddr = r_ptr;
        store_wdata = ERASED_BYTE;
        case (r_state)
            S_CLEAR, S_SWEEP: begin
                store_we = 1'b1;
            end
            S_EVAL: begin
                if ((prog_hit && !needs_erase)
                    || ((r_func == FUNC_PRELOAD) && in_span)) begin
                    store_we    = 1'b1;
                    store_waddr = ADDR_W'(r_addr);
                    store_wdata = r_data;
                end
            end
            S_PROG: begin
                store_we    = 1'b1;
                store_waddr = ADDR_W'(r_addr);
                store_wdata = r_data;
            end
            default: begin
                store_we = 1'b0;
            end
        endcase
    end

    // Row counter write port.
    always_comb begin
        cnt_we    = 1'b0;
        cnt_waddr = row_idx;
        cnt_wdata = cnt_new;
        case (r_state)
            S_CLEAR: begin
                cnt_we    = 32'(r_ptr) < 32'(NUM_ROWS);
                cnt_waddr = RIDX_W'(r_ptr);
                cnt_wdata = '0;
            end
            S_CNT_WR: begin
                cnt_we = 1'b1;
            end
            default: begin
                cnt_we = 1'b0;
            end
        endcase
    end

    // Byte store, read at the incoming address every cycle.
    always_ff @(posedge i_clk) begin
        if (store_we) begin
            r_store[store_waddr] <= store_wdata;
        end
        r_store_q <= r_store[ADDR_W'(i_access_address)];
    end

    // Row erase counters, read at the row under erase.
    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            r_row_cnt[cnt_waddr] <= cnt_wdata;
        end
        r_row_cnt_q <= r_row_cnt[row_idx];
    end

    // Payload registers that are always set before use.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_func <= t_func'(i_func);
            r_addr <= i_access_address;
            r_data <= i_write_data;
        end
        case (r_state)
            S_DIV: begin
                r_quot <= div_quot;
            end
            S_CNT_RD: begin
                r_off <= '0;
            end
            S_SWEEP: begin
                r_off <= r_off + 1'b1;
            end
            default: begin
                r_off <= r_off;
            end
        endcase
        if (r_state == S_DONE && out_free) begin
            r_out_read_data       <= r_res_rd;
            r_out_did_erase       <= r_res_erase;
            r_out_erase_total     <= r_erase_cnt;
            r_out_program_total   <= r_prog_cnt;
            r_out_rows_touched    <= r_touched;
            r_out_rows_amplified  <= r_amplified;
            r_out_max_row_erases  <= r_peak;
            r_out_inversion_total <= r_inv_cnt;
        end
    end

    // Control state and statistics.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_span      <= SPAN_RESET;
            r_ptr       <= '0;
            r_erase_cnt <= '0;
            r_prog_cnt  <= '0;
            r_inv_cnt   <= '0;
            r_last_row  <= '0;
            r_dir       <= DIR_NONE;
            r_seen      <= 1'b0;
            r_touched   <= '0;
            r_amplified <= '0;
            r_peak      <= '0;
            r_res_rd    <= '0;
            r_res_erase <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid) begin
                r_span <= i_cfg_data;
            end

            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_CLEAR: begin
                    r_ptr <= r_ptr + 1'b1;
                end
                S_IDLE: begin
                    r_res_rd    <= '0;
                    r_res_erase <= 1'b0;
                end
                S_EVAL: begin
                    if (r_func == FUNC_READ) begin
                        r_res_rd <= in_span ? r_store_q : ERASED_BYTE;
                    end
                    if (prog_hit && !needs_erase && r_prog_cnt != TOTAL_MAX) begin
                        r_prog_cnt <= r_prog_cnt + 1'b1;
                    end
                end
                S_CNT_RD: begin
                    // Start of the row: row index times the row size.
                    r_ptr <= ADDR_W'(32'(r_quot) * ROW_BYTES);
                end
                S_CNT_WR: begin
                    r_res_erase <= 1'b1;
                    if (r_erase_cnt != TOTAL_MAX) begin
                        r_erase_cnt <= r_erase_cnt + 1'b1;
                    end
                    if (r_row_cnt_q == 8'd0 && r_touched != ROWS_CAP) begin
                        r_touched <= r_touched + 1'b1;
                    end
                    if (r_row_cnt_q == 8'd1 && r_amplified != ROWS_CAP) begin
                        r_amplified <= r_amplified + 1'b1;
                    end
                    if (cnt_new > r_peak) begin
                        r_peak <= cnt_new;
                    end
                    // The first move between rows sets the direction.
                    if (r_seen && row_idx != r_last_row) begin
                        if (r_dir == DIR_NONE) begin
                            r_dir <= new_dir;
                        end else if (new_dir != r_dir && r_inv_cnt != TOTAL_MAX) begin
                            r_inv_cnt <= r_inv_cnt + 1'b1;
                        end
                    end
                    r_last_row <= row_idx;
                    r_seen     <= 1'b1;
                end
                S_SWEEP: begin
                    r_ptr <= r_ptr + 1'b1;
                end
                S_PROG: begin
                    if (r_prog_cnt != TOTAL_MAX) begin
                        r_prog_cnt <= r_prog_cnt + 1'b1;
                    end
                end
                default: begin
                    r_ptr <= r_ptr;
                end
            endcase
        end
    end

    assign o_in_ready        = (r_state == S_IDLE);
    assign o_cfg_ready       = 1'b1;
    assign o_out_valid       = r_out_valid;
    assign o_read_data       = r_out_read_data;
    assign o_did_erase       = r_out_did_erase;
    assign o_erase_total     = r_out_erase_total;
    assign o_program_total   = r_out_program_total;
    assign o_rows_touched    = r_out_rows_touched;
    assign o_rows_amplified  = r_out_rows_amplified;
    assign o_max_row_erases  = r_out_max_row_erases;
    assign o_inversion_total = r_out_inversion_total;

endmodule

`default_nettype wire

[rtl/frew_checker.sv]
`default_nettype none

module frew_checker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    input  wire logic                            o_in_ready,
    input  wire logic [1:0]                      i_func,
    input  wire logic [frew_pkg::ADDR_IN_W-1:0]  i_access_address,
    input  wire logic [frew_pkg::BYTE_W-1:0]     i_write_data,
    input  wire logic                            o_out_valid,
    input  wire logic                            i_out_ready,
    input  wire logic [frew_pkg::BYTE_W-1:0]     o_read_data,
    input  wire logic                            o_did_erase,
    input  wire logic [frew_pkg::TOTAL_W-1:0]    o_erase_total,
    input  wire logic [frew_pkg::TOTAL_W-1:0]    o_program_total,
    input  wire logic [frew_pkg::ROWS_W-1:0]     o_rows_touched,
    input  wire logic [frew_pkg::ROWS_W-1:0]     o_rows_amplified,
    input  wire logic [frew_pkg::BYTE_W-1:0]     o_max_row_erases,
    input  wire logic [frew_pkg::TOTAL_W-1:0]    o_inversion_total,
    input  wire logic                            i_cfg_valid,
    input  wire logic                            o_cfg_ready,
    input  wire logic [frew_pkg::SPAN_W-1:0]     i_cfg_data
);
    import frew_pkg::*;

    // Reset starts the clearing pass: no result and no input taken.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_ready)
        else $error("block not quiet after reset");

    // A stalled result beat holds its statistics.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_erase_total)
            && $stable(o_program_total) && $stable(o_did_erase))
        else $error("stalled result beat changed");

    // An erasing beat carries nonzero wear statistics and no read data.
    a_erase_stats: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_did_erase |-> o_erase_total != '0 && o_program_total != '0
            && o_rows_touched != '0 && o_max_row_erases != '0 && o_read_data == '0)
        else $error("erase reported without matching statistics");

    // Rows erased twice are a subset of rows erased at all.
    a_amp_le_touched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_rows_amplified <= o_rows_touched)
        else $error("amplified row count exceeds touched row count");

    // A peak above one implies at least one amplified row.
    a_peak_amp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_max_row_erases > 8'd1 |-> o_rows_amplified != '0)
        else $error("row erased twice but no amplified row counted");

endmodule

bind flash_row_erase_wear_model frew_checker u_frew_checker (.*);

`default_nettype wire
